@@ rtl/gsbp_pkg.sv @@
// Shared types, constants and microcode program for the Goertzel bin power block.
package gsbp_pkg;

	localparam int SampleW   = 16;
	localparam int CoefW     = 16;
	localparam int CountW    = 10;
	localparam int PowerW    = 23;
	localparam int FbW       = 18;
	localparam int ProdW     = FbW + SampleW;
	localparam int AccW      = ProdW + 2;
	localparam int CoefShift = 14;
	localparam int PowShift  = 15;
	localparam int GainShift = 4;
	localparam int StepW     = 4;

	localparam logic [CountW-1:0] BlockLenReset = CountW'(206);

	typedef logic [StepW-1:0] step_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_COEFFICIENT  = 1'b0,
		REG_BLOCK_LENGTH = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		A_D1 = 2'd0,
		A_D2 = 2'd1,
		A_FB = 2'd2
	} a_sel_t;

	typedef enum logic [1:0] {
		B_COEF = 2'd0,
		B_D1   = 2'd1,
		B_D2   = 2'd2
	} b_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_SUB  = 2'd3
	} acc_op_t;

	typedef enum logic [1:0] {
		C_NEXT     = 2'd0,
		C_WAIT_IN  = 2'd1,
		C_NO_MATCH = 2'd2,
		C_WAIT_OUT = 2'd3
	} cond_t;

	typedef struct packed {
		logic    take_in;
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		logic    recur;
		logic    fb_load;
		acc_op_t acc_op;
		logic    emit;
		cond_t   cond;
		step_t   target;
	} ctrl_word_t;

	typedef struct packed {
		logic match;
		logic out_busy;
	} dp_status_t;

	localparam step_t StepIdle = StepW'(0);
	localparam step_t StepLast = StepW'(9);

	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t w;
		w.take_in = 1'b0;
		w.a_sel   = A_D1;
		w.b_sel   = B_COEF;
		w.recur   = 1'b0;
		w.fb_load = 1'b0;
		w.acc_op  = ACC_HOLD;
		w.emit    = 1'b0;
		w.cond    = C_NEXT;
		w.target  = StepIdle;
		case (step)
			4'd0: begin
				w.take_in = 1'b1;
				w.cond    = C_WAIT_IN;
			end
			4'd1: begin
				w.a_sel = A_D1;
				w.b_sel = B_COEF;
			end
			4'd2: begin
				w.recur = 1'b1;
			end
			4'd3: begin
				w.cond = C_NO_MATCH;
			end
			4'd4: begin
				w.a_sel = A_D1;
				w.b_sel = B_COEF;
			end
			4'd5: begin
				w.fb_load = 1'b1;
				w.a_sel   = A_D1;
				w.b_sel   = B_D1;
			end
			4'd6: begin
				w.acc_op = ACC_LOAD;
				w.a_sel  = A_D2;
				w.b_sel  = B_D2;
			end
			4'd7: begin
				w.acc_op = ACC_ADD;
				w.a_sel  = A_FB;
				w.b_sel  = B_D2;
			end
			4'd8: begin
				w.acc_op = ACC_SUB;
			end
			4'd9: begin
				w.emit = 1'b1;
				w.cond = C_WAIT_OUT;
			end
			default: begin
				w.cond = C_NO_MATCH;
			end
		endcase
		return w;
	endfunction

endpackage

@@ rtl/gsbp_seq.sv @@
// Microcode sequencer: step counter, control store and conditional jumps.
module gsbp_seq import gsbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  dp_status_t status,
	output ctrl_word_t ctrl
);

	step_t pc_q;
	step_t pc_next;

	assign ctrl = ucode(pc_q);

	always_comb begin
		pc_next = pc_q + StepW'(1);
		case (ctrl.cond)
			C_NEXT:     pc_next = pc_q + StepW'(1);
			C_WAIT_IN:  pc_next = in_valid ? pc_q + StepW'(1) : pc_q;
			C_NO_MATCH: pc_next = status.match ? pc_q + StepW'(1) : ctrl.target;
			C_WAIT_OUT: pc_next = status.out_busy ? pc_q : ctrl.target;
			default:    pc_next = ctrl.target;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= StepIdle;
		end else begin
			pc_q <= pc_next;
		end
	end

`ifndef NO_ASSERTIONS
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= StepLast)
		else $error("step counter past end of program");

	a_take_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.take_in && in_valid) |=> (pc_q == StepIdle + StepW'(1)))
		else $error("accepted word did not start the update");

	a_emit_match: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> status.match)
		else $error("result step reached without block end");
`endif

endmodule

@@ rtl/gsbp_dp.sv @@
// Datapath: delays, shared multiplier, accumulator, counter and output register.
module gsbp_dp import gsbp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_word_t               ctrl,
	input  logic                     in_valid,
	input  logic signed [SampleW-1:0] sample_in,
	input  logic signed [CoefW-1:0]  coefficient,
	input  logic        [CountW-1:0] block_length,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic signed [PowerW-1:0] bin_power,
	output dp_status_t               status
);

	logic signed [SampleW-1:0] x_q;
	logic signed [SampleW-1:0] d1_q;
	logic signed [SampleW-1:0] d2_q;
	logic        [CountW-1:0]  cnt_q;
	logic        [CountW-1:0]  cnt_next;
	logic                      match_q;
	logic signed [FbW-1:0]     fb_q;
	logic signed [ProdW-1:0]   prod_q;
	logic signed [ProdW-1:0]   prod_c;
	logic signed [AccW-1:0]    acc_q;
	logic signed [AccW-1:0]    prod_ext;
	logic signed [FbW-1:0]     mul_a;
	logic signed [SampleW-1:0] mul_b;
	logic        [SampleW-1:0] fresh;
	logic                      out_valid_q;
	logic signed [PowerW-1:0]  bin_power_q;
	logic                      out_busy;
	logic                      do_emit;

	assign out_busy = out_valid_q && out_stall;
	assign do_emit  = ctrl.emit && !out_busy;
	assign cnt_next = cnt_q + CountW'(1);

	always_comb begin
		case (ctrl.a_sel)
			A_D1:    mul_a = {{(FbW-SampleW){d1_q[SampleW-1]}}, d1_q};
			A_D2:    mul_a = {{(FbW-SampleW){d2_q[SampleW-1]}}, d2_q};
			A_FB:    mul_a = fb_q;
			default: mul_a = '0;
		endcase
		case (ctrl.b_sel)
			B_COEF:  mul_b = coefficient;
			B_D1:    mul_b = d1_q;
			B_D2:    mul_b = d2_q;
			default: mul_b = '0;
		endcase
	end

	assign prod_c   = mul_a * mul_b;
	assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
	// Low bits of the floor-shifted feedback are all the wrapped sum needs.
	assign fresh    = x_q - d2_q + prod_q[CoefShift+SampleW-1:CoefShift];

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		if (ctrl.take_in && in_valid) begin
			x_q <= sample_in;
		end
		if (ctrl.fb_load) begin
			fb_q <= prod_q[CoefShift+FbW-1:CoefShift];
		end
		case (ctrl.acc_op)
			ACC_HOLD: acc_q <= acc_q;
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:  acc_q <= acc_q;
		endcase
		if (do_emit) begin
			bin_power_q <= {acc_q[PowShift+PowerW-GainShift-1:PowShift], {GainShift{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q        <= '0;
			d2_q        <= '0;
			cnt_q       <= '0;
			match_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.recur) begin
				d2_q    <= d1_q;
				d1_q    <= fresh;
				cnt_q   <= cnt_next;
				match_q <= (cnt_next == block_length);
			end else if (do_emit) begin
				d1_q    <= '0;
				d2_q    <= '0;
				cnt_q   <= '0;
				match_q <= 1'b0;
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign bin_power       = bin_power_q;
	assign status.match    = match_q;
	assign status.out_busy = out_busy;

endmodule

@@ rtl/goertzel_single_bin_power_top.sv @@
// Top level of the Goertzel single-bin power detector.
//
// Input channel: one signed 16-bit sample word per handshake (in_valid/in_stall).
// Output channel: one signed 23-bit power word per finished block
// (out_valid/out_stall).
// Configuration: write_en/write_index/write_data set the Q14 coefficient
// (index 0) and the block length (index 1); write only while the block is idle.
// Sequencing: a small microcode program drives one shared
// 18x16 multiplier. A sample that does not end a block passes through the
// steps accept, multiply, update and test before the next acceptance. The
// sample that ends a block runs 6 more steps through the same multiplier for
// d1^2, d2^2 and the cross term; its power word is registered at the result
// step, after which the program returns to take the next sample.
// The output register holds a finished word while the receiver stalls; the
// program waits at its result step only if a previous word is still unclaimed.
// Reset: clears both delays, the sample counter, the output valid flag, the
// coefficient to zero and the block length to 206.
module goertzel_single_bin_power_top import gsbp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [SampleW-1:0] sample_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [PowerW-1:0]  bin_power,
	input  logic                      write_en,
	input  logic                      write_index,
	input  logic        [CoefW-1:0]   write_data
);

	logic signed [CoefW-1:0]  coefficient_q;
	logic        [CountW-1:0] block_length_q;
	ctrl_word_t               ctrl;
	dp_status_t               status;
	reg_idx_t                 wr_idx;

	assign wr_idx = reg_idx_t'(write_index);

	// Hold configuration; update on a write strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefficient_q  <= '0;
			block_length_q <= BlockLenReset;
		end else if (write_en) begin
			case (wr_idx)
				REG_COEFFICIENT:  coefficient_q  <= write_data;
				REG_BLOCK_LENGTH: block_length_q <= write_data[CountW-1:0];
				default:          coefficient_q  <= coefficient_q;
			endcase
		end
	end

	// Stall the sender except at the program's input step.
	assign in_stall = !ctrl.take_in;

	gsbp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.ctrl     (ctrl)
	);

	gsbp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.in_valid     (in_valid),
		.sample_in    (sample_in),
		.coefficient  (coefficient_q),
		.block_length (block_length_q),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.bin_power    (bin_power),
		.status       (status)
	);

endmodule

@@ tb/goertzel_checker.sv @@
// Scoreboard for the Goertzel bin power block: tracks its state, predicts and checks power words.
`timescale 1ns / 1ps

module goertzel_checker import gsbp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic signed [SampleW-1:0] sample_in,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [PowerW-1:0]  bin_power,
	input  logic                      write_en,
	input  logic                      write_index,
	input  logic        [CoefW-1:0]   write_data,
	output int unsigned               words_due,
	output int unsigned               faults
);

	logic signed [CoefW-1:0]   coef_q;
	logic        [CountW-1:0]  block_len;
	logic        [CountW-1:0]  sample_cnt;
	logic signed [SampleW-1:0] lead;
	logic signed [SampleW-1:0] lag;
	logic signed [PowerW-1:0]  power_due[$];
	int unsigned               fault_tally;

	always @(posedge clk or negedge arst_n) begin : track
		longint                    fb;
		longint                    d1w;
		longint                    d2w;
		longint                    energy;
		logic signed [SampleW-1:0] fresh;
		logic signed [PowerW-1:0]  due_word;
		if (!arst_n) begin
			coef_q      = '0;
			block_len   = BlockLenReset;
			sample_cnt  = '0;
			lead        = '0;
			lag         = '0;
			fault_tally = 0;
			power_due.delete();
		end else begin
			// retire the oldest expected power word
			if (out_valid && !out_stall) begin
				if (power_due.size() == 0) begin
					$error("bin_power: no word expected, got %0d", bin_power);
					fault_tally++;
				end else begin
					due_word = power_due.pop_front();
					if (bin_power !== due_word) begin
						$error("bin_power mismatch: expected %0d, got %0d", due_word, bin_power);
						fault_tally++;
					end
				end
			end
			if (write_en) begin
				if (write_index == REG_COEFFICIENT)
					coef_q = write_data;
				else
					block_len = write_data[CountW-1:0];
			end
			if (in_valid && !in_stall) begin
				// recurrence, floor shift of the feedback, wrap to the sample width
				fb    = (longint'(lead) * longint'(coef_q)) >>> CoefShift;
				fresh = SampleW'(longint'(sample_in) - longint'(lag) + fb);
				lag   = lead;
				lead  = fresh;
				sample_cnt = sample_cnt + 1'b1;
				if (sample_cnt == block_len) begin
					d1w    = lead;
					d2w    = lag;
					energy = d1w * d1w + d2w * d2w
						- (((d1w * longint'(coef_q)) >>> CoefShift) * d2w);
					power_due.push_back(PowerW'((energy >>> PowShift) <<< GainShift));
					lead       = '0;
					lag        = '0;
					sample_cnt = '0;
				end
			end
		end
		words_due <= power_due.size();
		faults    <= fault_tally;
	end

endmodule

@@ tb/testbench.sv @@
// Top of the Goertzel bin power testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench import gsbp_pkg::*;;

	localparam logic signed [SampleW-1:0] SMax      = 16'sh7FFF;
	localparam logic signed [SampleW-1:0] SMin      = 16'sh8000;
	localparam int unsigned               IdleLimit = 2000;
	localparam int unsigned               RandItems = 700;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic signed [SampleW-1:0] sample_in   = '0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	logic signed [PowerW-1:0]  bin_power;
	logic                      write_en    = 1'b0;
	logic                      write_index = REG_COEFFICIENT;
	logic        [CoefW-1:0]   write_data  = '0;

	int unsigned words_due;
	int unsigned fail_count;
	int unsigned rx_wait    = 0;
	int unsigned idle_count = 0;
	bit          quiet_tx   = 1'b0;
	bit          quiet_rx   = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	goertzel_single_bin_power_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bin_power  (bin_power),
		.write_en   (write_en),
		.write_index(write_index),
		.write_data (write_data)
	);

	goertzel_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bin_power  (bin_power),
		.write_en   (write_en),
		.write_index(write_index),
		.write_data (write_data),
		.words_due  (words_due),
		.faults     (fail_count)
	);

	// Receiver: after each taken power word, stall for a drawn number of cycles,
	// or not at all while the quiet flag is up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait   <= 0;
		end else if (out_valid && !out_stall) begin : rx_draw
			int unsigned n;
			n = quiet_rx ? 0 : $urandom_range(0, 14);
			rx_wait   <= n;
			out_stall <= (n != 0);
		end else if (rx_wait != 0) begin
			rx_wait   <= rx_wait - 1;
			out_stall <= (rx_wait > 1);
		end
	end

	// Watchdog: count cycles in which no word moves on either channel and no
	// register is written; a hang ends the run as a failure.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || write_en)
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count == IdleLimit) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Mix of full-scale extremes, small values near zero and full-range noise.
	function automatic logic signed [SampleW-1:0] draw_sample();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 1) ? SMax : SMin;
			1:       return SampleW'(int'($urandom_range(0, 511)) - 256);
			default: return SampleW'($urandom);
		endcase
	endfunction

	// Present one sample word after a drawn gap and hold it until taken.
	// Call at a rising edge; returns at the edge that accepted the word, with
	// in_valid still high so a back-to-back word needs no extra drop.
	task automatic push_sample(input logic signed [SampleW-1:0] x);
		int unsigned gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= x;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop the input, wait until every expected power word has been taken, then
	// give the block time to finish a sample that ends no block.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Write both registers on back-to-back edges; only call while idle.
	task automatic set_config(input logic signed [CoefW-1:0] coef,
			input logic [CountW-1:0] blen);
		write_en    <= 1'b1;
		write_index <= REG_COEFFICIENT;
		write_data  <= coef;
		@(posedge clk);
		write_index <= REG_BLOCK_LENGTH;
		write_data  <= CoefW'(blen);
		@(posedge clk);
		write_en    <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned             blen;
		int unsigned             nsamp;
		int unsigned             fed;
		logic signed [CoefW-1:0] coef;
		fed = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Run one block on the reset settings: zero coefficient, 206 samples.
		repeat (206) push_sample(draw_sample());
		settle();

		// Directed: full-scale input with the largest coefficient wraps the delays.
		set_config(SMax, 10'd3);
		repeat (3) push_sample(SMax);
		settle();
		// Most negative coefficient and input, two-sample blocks.
		set_config(SMin, 10'd2);
		repeat (2) push_sample(SMin);
		settle();
		// Zero coefficient, one-sample blocks: each word ends its own block.
		set_config('0, 10'd1);
		push_sample(SMin);
		push_sample(SMax);
		push_sample('0);
		push_sample(-16'sd1);
		settle();
		// Unity feedback with alternating full-scale input.
		set_config(16'sd16384, 10'd4);
		repeat (2) begin
			push_sample(SMax);
			push_sample(SMin);
		end
		settle();
		// Negative full-scale feedback drives the cross term positive.
		set_config(SMin, 10'd5);
		repeat (5) push_sample(SMax);
		settle();
		// Leave a block half done; the next phase picks it up with new settings.
		set_config(16'sd27000, 10'd6);
		repeat (3) push_sample(draw_sample());
		settle();

		// Random phases: mostly short blocks, a few longer ones, random settings.
		while (fed < RandItems) begin
			quiet_tx = ($urandom_range(0, 4) == 0);
			quiet_rx = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 4))
				0:       coef = SMin;
				1:       coef = SMax;
				2:       coef = '0;
				default: coef = CoefW'($urandom);
			endcase
			case ($urandom_range(0, 9))
				7, 8:    blen = $urandom_range(17, 80);
				9:       blen = $urandom_range(81, 200);
				default: blen = $urandom_range(1, 16);
			endcase
			nsamp = blen * $urandom_range(1, 3);
			// Sometimes stop mid-block so the counter carries into new settings.
			if ($urandom_range(0, 3) == 0)
				nsamp += $urandom_range(0, blen - 1);
			set_config(coef, CountW'(blen));
			repeat (nsamp) push_sample(draw_sample());
			fed += nsamp;
			settle();
		end

		// Lower the block length to zero mid-block: the count has already passed
		// it, so it runs to the top, wraps, and ends the block on reaching zero.
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		coef = CoefW'($urandom);
		set_config(coef, 10'd20);
		repeat (10) push_sample(draw_sample());
		settle();
		set_config(coef, '0);
		repeat (1014) push_sample(draw_sample());
		settle();

		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
